// ===== design/open_address_hash_table_unit_macros.svh =====
// Assertion macros used by the hash table unit's controller.
`ifndef OPEN_ADDRESS_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_UNIT_MACROS_SVH

// The condition a holds and, in the same cycle, c holds too.
`define OAHT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("hash table unit assertion failed");

// The condition a holds and, in the next cycle, c holds.
`define OAHT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("hash table unit assertion failed");

`endif

// ===== design/oaht_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package oaht_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int HASH_W = 32;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int MOD_W  = 11;
  localparam int CNT_W  = 11;
  localparam int FUNC_W = 3;

  localparam logic [MOD_W-1:0]  MOD_RESET     = 11'd1021;
  localparam logic [HASH_W-1:0] HASH_EMPTY    = 32'd0;
  localparam logic [HASH_W-1:0] HASH_TOMB     = 32'd1;
  localparam logic [HASH_W-1:0] MIN_REAL_HASH = 32'd2;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_UPSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming word
    logic clr_init;   // restart the clearing sweep and zero the live count
    logic clr_step;   // write one empty slot of the sweep
    logic div_start;  // start the remainder unit on the incoming hash
    logic first_set;  // load the first probe slot
    logic rd;         // read the slot at the probe index
    logic adv;        // move to the next probe slot
    logic wr_new;     // store a new entry, live count up
    logic wr_upd;     // overwrite key and value in place
    logic wr_tomb;    // leave a tombstone, live count down
    logic res_set;    // load the result registers
    logic res_ok;
    logic res_fv;     // take the found value from the slot just read
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic mod_zero;
    logic in_key_zero;
    logic slot_empty;
    logic slot_tomb;
    logic slot_match;
    logic step_last;
    logic clr_last;
  } sts_t;

endpackage

// ===== design/oaht_div.sv =====
// Restoring remainder unit, one dividend bit per cycle.
module oaht_div import oaht_pkg::*; #(
  parameter int DW = HASH_W,
  parameter int MW = MOD_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [MW-1:0] divisor,
  output logic [MW-1:0] rem,
  output logic          done
);

  localparam int CW = $clog2(DW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [DW-1:0]   dvd_r, dvd_nxt;
  logic [MW-1:0]   rem_r, rem_nxt;
  logic [MW:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = MW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[MW-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== design/oaht_dp.sv =====
// Datapath: slot memory, probe index, counts, remainder unit and result registers.
module oaht_dp import oaht_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [MOD_W-1:0]  modulus,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [HASH_W-1:0] in_key_hash,
  input  logic [VAL_W-1:0]  in_value,
  output logic              res_ok,
  output logic [VAL_W-1:0]  res_fv,
  output logic [CNT_W-1:0]  live_count
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int EW = HASH_W + KEY_W + VAL_W;

  logic [EW-1:0]     mem [TABLE_SIZE];
  logic [EW-1:0]     rd_r;
  logic [HASH_W-1:0] hash_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  value_r;
  logic [IW-1:0]     idx_r;
  logic [IW:0]       step_r;
  logic [IW:0]       step_nxt;
  logic [IW-1:0]     clr_idx_r;
  logic [CNT_W-1:0]  live_r;
  logic              ok_r;
  logic [VAL_W-1:0]  fv_r;
  logic [HASH_W-1:0] hash_in;
  logic [HASH_W-1:0] first_full;
  logic [MOD_W-1:0]  rem;
  logic              div_done;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [HASH_W-1:0] rd_hash;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_value;

  assign hash_in = (in_key_hash < MIN_REAL_HASH) ? MIN_REAL_HASH : in_key_hash;

  oaht_div #(.DW(HASH_W), .MW(MOD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (hash_in),
    .divisor  (modulus),
    .rem      (rem),
    .done     (div_done)
  );

  assign first_full = (modulus == '0) ? hash_r : {{(HASH_W-MOD_W){1'b0}}, rem};
  assign step_nxt   = step_r + 1'b1;
  assign {rd_hash, rd_key, rd_value} = rd_r;

  always_comb begin
    wr_en   = cmd.clr_step | cmd.wr_new | cmd.wr_upd | cmd.wr_tomb;
    wr_addr = cmd.clr_step ? clr_idx_r : idx_r;
    wr_data = {hash_r, key_r, value_r};
    if (cmd.clr_step) begin
      wr_data = '0;
    end else if (cmd.wr_tomb) begin
      wr_data = {HASH_TOMB, {(KEY_W+VAL_W){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      live_r    <= '0;
    end else begin
      if (cmd.clr_init) begin
        clr_idx_r <= '0;
        live_r    <= '0;
      end else if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.wr_new) begin
        live_r <= live_r + 1'b1;
      end else if (cmd.wr_tomb) begin
        live_r <= live_r - 1'b1;
      end
    end
    if (cmd.load) begin
      hash_r  <= hash_in;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (cmd.first_set) begin
      idx_r  <= first_full[IW-1:0];
      step_r <= '0;
    end else if (cmd.adv) begin
      idx_r  <= idx_r + step_nxt[IW-1:0];
      step_r <= step_nxt;
    end
    if (cmd.res_set) begin
      ok_r <= cmd.res_ok;
      fv_r <= cmd.res_fv ? rd_value : '0;
    end
  end

  always_comb begin
    sts.div_done    = div_done;
    sts.mod_zero    = (modulus == '0);
    sts.in_key_zero = (in_key == '0);
    sts.slot_empty  = (rd_hash == HASH_EMPTY);
    sts.slot_tomb   = (rd_hash == HASH_TOMB);
    sts.slot_match  = (rd_hash == hash_r) && (rd_key == key_r);
    sts.step_last   = (step_r == (IW+1)'(TABLE_SIZE));
    sts.clr_last    = (clr_idx_r == {IW{1'b1}});
  end

  assign res_ok     = ok_r;
  assign res_fv     = fv_r;
  assign live_count = live_r;

endmodule

// ===== design/oaht_ctrl.sv =====
// Controller state machine: sequences clearing, division, probing and result hand-off.
module oaht_ctrl import oaht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sts_t              sts,
  output cmd_t              cmd
);

  `include "open_address_hash_table_unit_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_CLR, S_DIV, S_RD, S_CHK, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              clr_rep_r, clr_rep_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic              is_store;

  assign is_store = (func_r == FN_INSERT) || (func_r == FN_UPSERT);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    clr_rep_nxt   = clr_rep_r;
    func_nxt      = func_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          func_nxt = in_func;
          if (in_func == FN_CLEAR) begin
            cmd.clr_init = 1'b1;
            clr_rep_nxt  = 1'b1;
            state_nxt    = S_CLR;
          end else if (in_func > FN_CLEAR || sts.in_key_zero) begin
            cmd.res_set   = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          if (clr_rep_r) begin
            cmd.res_set   = 1'b1;
            cmd.res_ok    = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts.mod_zero || sts.div_done) begin
          cmd.first_set = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_OUT;
        if (is_store) begin
          if (sts.slot_empty || sts.slot_tomb) begin
            cmd.wr_new = 1'b1;
            cmd.res_ok = 1'b1;
          end else if (sts.slot_match) begin
            cmd.wr_upd = (func_r == FN_UPSERT);
            cmd.res_ok = (func_r == FN_UPSERT);
          end else if (!sts.step_last) begin
            cmd.adv   = 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          if (sts.slot_empty) begin
            cmd.res_ok = 1'b0;
          end else if (sts.slot_match) begin
            cmd.wr_tomb = (func_r == FN_REMOVE);
            cmd.res_ok  = 1'b1;
            cmd.res_fv  = 1'b1;
          end else if (!sts.step_last) begin
            cmd.adv   = 1'b1;
            state_nxt = S_RD;
          end
        end
        if (state_nxt == S_OUT) begin
          cmd.res_set   = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      clr_rep_r   <= 1'b0;
      func_r      <= FN_INSERT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_rep_r   <= clr_rep_nxt;
      func_r      <= func_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `OAHT_ASSERT_IMP(a_busy_while_result, out_valid_r, in_stall)
  `OAHT_ASSERT_NXT(a_accept_leaves_idle, state_r == S_IDLE && in_valid, state_r != S_IDLE)
  `OAHT_ASSERT_NXT(a_taken_goes_idle, state_r == S_OUT && !out_stall, state_r == S_IDLE)
  `OAHT_ASSERT_IMP(a_one_write, cmd.wr_new || cmd.wr_upd || cmd.wr_tomb, state_r == S_CHK)

endmodule

// ===== design/open_address_hash_table_unit.sv =====
// Top level of the open-addressed hash table unit with quadratic probing.
//
//   port group   direction  handshake              word
//   in_*         in         in_valid / in_stall    func, key, key_hash, value
//   out_*        out        out_valid / out_stall  ok, found_value, entry_count
//   APB          in/out     psel, penable, pready  start_modulus at address 0
//
// An item is accepted in the idle state, then passes through the bit-serial remainder unit
// (skipped when start_modulus is zero), then a read state and a check state per probed slot,
// because the single slot memory has a registered read port, and then the result register.
// A clear sweeps every slot of the table before the result.
// After reset the same sweep empties every slot; in_stall stays high throughout it, while
// register writes are taken at any time.
// A result waits in its register while out_stall is high; no new word is taken then.
module open_address_hash_table_unit import oaht_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [HASH_W-1:0] in_key_hash,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_ok,
  output logic [VAL_W-1:0]  out_found_value,
  output logic [CNT_W-1:0]  out_entry_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // The only register sits at byte address 0; paddr bit 2 selects beyond it.
  localparam logic REG_START_MODULUS = 1'b0;

  logic [MOD_W-1:0] modulus_r;
  cmd_t             cmd;
  sts_t             sts;

  // The user must write the start modulus only while no word is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_START_MODULUS) begin
      modulus_r <= pwdata[MOD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_START_MODULUS) ? {{(32-MOD_W){1'b0}}, modulus_r} : '0;
  assign pready = 1'b1;

  // The controller decides each step; the datapath holds the table and the counts.
  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  oaht_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .modulus     (modulus_r),
    .in_key      (in_key),
    .in_key_hash (in_key_hash),
    .in_value    (in_value),
    .res_ok      (out_ok),
    .res_fv      (out_found_value),
    .live_count  (out_entry_count)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the open-addressed hash table unit.
`timescale 1ns / 100ps

module tb_top;
  import oaht_pkg::*;

  localparam int SLOTS = TABLE_SIZE_DEF;
  localparam logic [2:0] ADDR_START_MOD = 3'd0;
  localparam int HOLD_CYCLES = 300;

  // An item as the sender offers it.
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] key_hash;
    logic [VAL_W-1:0]  value;
  } op_word_t;

  // A result as the unit returns it.
  typedef struct {
    logic             ok;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] entry_count;
  } reply_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [KEY_W-1:0]  in_key = '0;
  logic [HASH_W-1:0] in_key_hash = '0;
  logic [VAL_W-1:0]  in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_ok;
  logic [VAL_W-1:0]  out_found_value;
  logic [CNT_W-1:0]  out_entry_count;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  open_address_hash_table_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_key(in_key), .in_key_hash(in_key_hash), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ok(out_ok), .out_found_value(out_found_value), .out_entry_count(out_entry_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table, kept by the predictor.
  logic [HASH_W-1:0] shadow_hash [SLOTS];
  logic [KEY_W-1:0]  shadow_key  [SLOTS];
  logic [VAL_W-1:0]  shadow_val  [SLOTS];
  int unsigned       shadow_live;
  logic [MOD_W-1:0]  shadow_mod;

  op_word_t    pending_ops[$];
  reply_word_t awaited_replies[$];
  int          error_count = 0;
  int          ops_sent = 0;
  int          replies_seen = 0;
  bit          hold_off = 1'b0;
  int          hold_count = 0;

  // Keys in use by the stimulus, so that removes and lookups often hit.
  logic [KEY_W-1:0]  known_keys[$];
  logic [HASH_W-1:0] known_hashes[$];

  function automatic int unsigned first_probe(logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] s;
    s = (shadow_mod != 0) ? (h % shadow_mod) : h;
    return s & (SLOTS - 1);
  endfunction

  // Result codes of a store probe: no room, a free slot, or the key itself.
  typedef enum int {PROBE_FULL, PROBE_FREE, PROBE_HIT} probe_res_t;

  function automatic probe_res_t seek_store_slot(logic [HASH_W-1:0] h,
                                                 logic [KEY_W-1:0] k,
                                                 output int unsigned pos);
    int unsigned idx, step;
    idx = first_probe(h);
    step = 0;
    pos = 0;
    forever begin
      if (shadow_hash[idx] < MIN_REAL_HASH) begin
        pos = idx;
        return PROBE_FREE;
      end
      if (shadow_hash[idx] == h && shadow_key[idx] == k) begin
        pos = idx;
        return PROBE_HIT;
      end
      step++;
      if (step > SLOTS) return PROBE_FULL;
      idx = (idx + step) & (SLOTS - 1);
    end
  endfunction

  function automatic bit seek_key(logic [HASH_W-1:0] h, logic [KEY_W-1:0] k,
                                  output int unsigned pos);
    int unsigned idx, step;
    idx = first_probe(h);
    step = 0;
    pos = 0;
    forever begin
      if (shadow_hash[idx] == HASH_EMPTY) return 1'b0;
      if (shadow_hash[idx] >= MIN_REAL_HASH && shadow_hash[idx] == h &&
          shadow_key[idx] == k) begin
        pos = idx;
        return 1'b1;
      end
      step++;
      if (step > SLOTS) return 1'b0;
      idx = (idx + step) & (SLOTS - 1);
    end
  endfunction

  function automatic void empty_shadow();
    for (int i = 0; i < SLOTS; i++) shadow_hash[i] = HASH_EMPTY;
    shadow_live = 0;
  endfunction

  function automatic void place_entry(int unsigned pos, logic [HASH_W-1:0] h,
                                      logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    shadow_hash[pos] = h;
    shadow_key[pos] = k;
    shadow_val[pos] = v;
    shadow_live++;
  endfunction

  // Applies one accepted word to the shadow table and returns its result.
  function automatic reply_word_t apply_table_op(op_word_t op);
    reply_word_t r;
    logic [HASH_W-1:0] h;
    int unsigned pos;
    probe_res_t pr;
    r.ok = 1'b0;
    r.found_value = '0;
    h = (op.key_hash < MIN_REAL_HASH) ? MIN_REAL_HASH : op.key_hash;
    if (op.func == FN_CLEAR) begin
      empty_shadow();
      r.ok = 1'b1;
    end else if (op.func <= FN_LOOKUP && op.key != 0) begin
      case (op.func)
        FN_INSERT, FN_UPSERT: begin
          pr = seek_store_slot(h, op.key, pos);
          if (pr == PROBE_FREE) begin
            place_entry(pos, h, op.key, op.value);
            r.ok = 1'b1;
          end else if (pr == PROBE_HIT && op.func == FN_UPSERT) begin
            shadow_val[pos] = op.value;
            r.ok = 1'b1;
          end
        end
        FN_REMOVE: begin
          if (seek_key(h, op.key, pos)) begin
            r.found_value = shadow_val[pos];
            shadow_hash[pos] = HASH_TOMB;
            shadow_live--;
            r.ok = 1'b1;
          end
        end
        default: begin
          if (seek_key(h, op.key, pos)) begin
            r.found_value = shadow_val[pos];
            r.ok = 1'b1;
          end
        end
      endcase
    end
    r.entry_count = shadow_live[CNT_W-1:0];
    return r;
  endfunction

  // A word is taken at the rising edge where in_valid is high and in_stall is low.
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      awaited_replies.push_back(apply_table_op(pending_ops.pop_front()));
      ops_sent++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: bursts of words with random gaps between them, changing at the falling edge.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_func <= pending_ops[0].func;
          in_key <= pending_ops[0].key;
          in_key_hash <= pending_ops[0].key_hash;
          in_value <= pending_ops[0].value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // Receiver stall: its own pattern, plus a long hold-off counted here when asked for.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_off && hold_count < HOLD_CYCLES) begin
      hold_count++;
      out_stall <= 1'b1;
    end
    else if (stall_phase % 200 < 60) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    reply_word_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        $error("result with no expectation waiting");
        error_count++;
      end else begin
        exp_r = awaited_replies.pop_front();
        if (out_ok !== exp_r.ok) begin
          $error("ok: expected %0d, got %0d", exp_r.ok, out_ok);
          error_count++;
        end
        if (out_found_value !== exp_r.found_value) begin
          $error("found_value: expected %h, got %h", exp_r.found_value, out_found_value);
          error_count++;
        end
        if (out_entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, out_entry_count);
          error_count++;
        end
      end
    end
  end

  task automatic write_start_mod(logic [MOD_W-1:0] m);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_START_MOD;
    pwdata <= 32'(m);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_mod = m;
  endtask

  task automatic queue_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                          logic [HASH_W-1:0] h, logic [VAL_W-1:0] v);
    op_word_t op;
    op.func = f;
    op.key = k;
    op.key_hash = h;
    op.value = v;
    pending_ops.push_back(op);
  endtask

  // Waits until every word is sent and answered, then lets a clear sweep pass.
  task automatic drain();
    while (pending_ops.size() != 0 || awaited_replies.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SLOTS + 100) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Well-formed traffic: mostly operations on keys seen before, some fresh keys and noise.
  task automatic queue_random_ops(int n, int key_pool);
    logic [KEY_W-1:0] k;
    logic [HASH_W-1:0] h;
    int i, pick, sel;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (known_keys.size() == 0 || pick < 30 || known_keys.size() < key_pool && pick < 45) begin
        k = rand64();
        if (k == 0) k = 1;
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom();
        known_keys.push_back(k);
        known_hashes.push_back(h);
      end else begin
        sel = $urandom_range(0, known_keys.size() - 1);
        k = known_keys[sel];
        h = known_hashes[sel];
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) queue_op(FN_INSERT, k, h, rand64());
      else if (pick < 50) queue_op(FN_UPSERT, k, h, rand64());
      else if (pick < 70) queue_op(FN_REMOVE, k, h, rand64());
      else if (pick < 94) queue_op(FN_LOOKUP, k, h, rand64());
      else if (pick < 96) queue_op(FN_CLEAR, rand64(), $urandom(), rand64());
      else if (pick < 98) queue_op(FN_LOOKUP, '0, $urandom(), rand64());
      else queue_op(3'($urandom_range(5, 7)), rand64(), $urandom(), rand64());
    end
  endtask

  initial begin
    empty_shadow();
    shadow_mod = MOD_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every operation, forced hashes, zero key, unused codes.
    queue_op(FN_LOOKUP, 64'h1, 32'h0, '0);
    queue_op(FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_op(FN_INSERT, 64'h1, 32'h0, 64'h0123_4567_89AB_CDEF);
    queue_op(FN_INSERT, 64'h2, 32'h1, 64'hAAAA_5555_AAAA_5555);
    queue_op(FN_INSERT, 64'h1, 32'h2, '0);
    queue_op(FN_INSERT, 64'h3, 32'h2, 64'h5555_AAAA_5555_AAAA);
    queue_op(FN_UPSERT, 64'h1, 32'h0, 64'hDEAD_BEEF);
    queue_op(FN_UPSERT, 64'h4, 32'h7FF, 64'h4);
    queue_op(FN_LOOKUP, 64'h1, 32'h2, '0);
    queue_op(FN_REMOVE, 64'h2, 32'h2, '0);
    queue_op(FN_LOOKUP, 64'h3, 32'h2, '0);
    queue_op(FN_REMOVE, 64'h2, 32'h2, '0);
    queue_op(FN_INSERT, 64'h5, 32'h2, 64'h5);
    queue_op(FN_INSERT, '0, 32'h10, 64'h1);
    queue_op(FN_REMOVE, '0, 32'h10, '0);
    queue_op(3'd5, 64'h1, 32'h2, '0);
    queue_op(3'd7, 64'h1, 32'h2, '0);
    queue_op(FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0);
    queue_op(FN_CLEAR, '0, '0, '0);
    queue_op(FN_LOOKUP, 64'h1, 32'h0, '0);
    drain();

    // Long hold-off while words keep coming, so the unit stalls its input.
    queue_random_ops(20, 16);
    hold_off = 1'b1;
    wait (hold_count == HOLD_CYCLES);
    hold_off = 1'b0;
    drain();

    // Random phases under several start moduli, extremes among them.
    write_start_mod(11'd0);
    queue_random_ops(90, 40);
    drain();
    write_start_mod(11'd1);
    queue_random_ops(60, 20);
    queue_op(FN_CLEAR, '0, '0, '0);
    drain();
    write_start_mod(11'd2047);
    queue_random_ops(90, 40);
    drain();
    write_start_mod(11'd7);
    known_keys.delete();
    known_hashes.delete();
    queue_random_ops(120, 60);
    drain();
    write_start_mod(11'd1024);
    queue_random_ops(60, 30);
    drain();
    write_start_mod(11'd1021);
    queue_random_ops(80, 40);
    drain();

    $display("Covered %0d words and %0d checked results over six start moduli,",
             ops_sent, replies_seen);
    $display("including forced hashes, zero keys, unused codes, clears and a long stall.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
